// File: rtl/dual_motor_brake_supervisor_defines.svh
// Assertion helpers for the brake supervisor checker.
`ifndef DUAL_MOTOR_BRAKE_SUPERVISOR_DEFINES_SVH
`define DUAL_MOTOR_BRAKE_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define DMBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define DMBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dmbs_pkg.sv
package dmbs_pkg;

  typedef enum logic [2:0] {
    REG_STOP_LEVEL          = 3'd0,
    REG_RESTART_LEVEL       = 3'd1,
    REG_RPM_STOP_LEVEL      = 3'd2,
    REG_SETTLE_TICKS        = 3'd3,
    REG_BRAKE_DELAY_TICKS   = 3'd4,
    REG_RELEASE_DELAY_TICKS = 3'd5,
    REG_FILTER_ALPHA        = 3'd6
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned FracW    = 16;
  localparam int unsigned FlagW    = 5;

  localparam logic [14:0] StopLevelRst    = 15'd1638;
  localparam logic [14:0] RestartLevelRst = 15'd3277;
  localparam logic [14:0] RpmStopLevelRst = 15'd400;
  localparam logic [7:0]  SettleTicksRst  = 8'd10;
  localparam logic [15:0] BrakeDelayRst   = 16'd50;
  localparam logic [7:0]  ReleaseDelayRst = 8'd50;
  localparam logic [15:0] FilterAlphaRst  = 16'd6554;

  // Result status bits, throttle_released in bit 0.
  typedef struct packed {
    logic clear_integrators;
    logic release_waiting;
    logic brake_engage;
    logic speed_settled;
    logic throttle_released;
  } flags_t;

endpackage

// File: rtl/dual_motor_brake_supervisor.sv
// Dual motor brake supervisor.
// Input stream: one transaction per control tick with both throttle commands
// (signed Q1.15) and both measured speeds (signed, SPEED_BITS wide).
// Output stream: one transaction per input, carrying the status flags and
// the integer part of both filtered speeds.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
// clock edge; unknown indexes are ignored. Write only while the block is idle.
// Path: an accepted transaction is held in the input register, then moves into
// the result register once the result register is free or being taken.
// Throughput: one transaction per cycle while the receiver does not stall; the
// filter multiply-accumulate and the flag and countdown updates for a tick are
// combinational, between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; s_axis_tready drops once both are full.
// Reset clears all flags, filters and countdowns, loads the settle counters
// with 10 and restores the default configuration.
module dual_motor_brake_supervisor
  import dmbs_pkg::*;
#(
  parameter int unsigned SPEED_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // throttle_one, throttle_two, speed_one, speed_two, zero pad
  input  logic [((2*ThrW+2*SPEED_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // throttle_released, speed_settled, brake_engage, release_waiting,
  // clear_integrators, filtered_speed_one, filtered_speed_two, zero pad
  output logic [((FlagW+2*SPEED_BITS+7)/8)*8-1:0]  m_axis_tdata,
  input  logic                                     cfg_we_i,
  input  logic [CfgIdxW-1:0]                       cfg_idx_i,
  input  logic [CfgDataW-1:0]                      cfg_data_i
);

  localparam int unsigned SB    = SPEED_BITS;
  localparam int unsigned AW    = SB + FracW;
  localparam int unsigned DW    = AW + 1;
  localparam int unsigned PW    = DW + 17;
  localparam int unsigned CW    = ((AW > 31) ? AW : 31) + 2;
  localparam int unsigned IN_W  = ((2*ThrW+2*SB+7)/8)*8;
  localparam int unsigned OUT_W = ((FlagW+2*SB+7)/8)*8;

  // configuration
  logic [14:0] stop_level_q, restart_level_q, rpm_stop_level_q;
  logic [7:0]  settle_ticks_q, release_delay_q;
  logic [15:0] brake_delay_q, filter_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_level_q     <= StopLevelRst;
      restart_level_q  <= RestartLevelRst;
      rpm_stop_level_q <= RpmStopLevelRst;
      settle_ticks_q   <= SettleTicksRst;
      brake_delay_q    <= BrakeDelayRst;
      release_delay_q  <= ReleaseDelayRst;
      filter_alpha_q   <= FilterAlphaRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STOP_LEVEL:          stop_level_q     <= cfg_data_i[14:0];
        REG_RESTART_LEVEL:       restart_level_q  <= cfg_data_i[14:0];
        REG_RPM_STOP_LEVEL:      rpm_stop_level_q <= cfg_data_i[14:0];
        REG_SETTLE_TICKS:        settle_ticks_q   <= cfg_data_i[7:0];
        REG_BRAKE_DELAY_TICKS:   brake_delay_q    <= cfg_data_i;
        REG_RELEASE_DELAY_TICKS: release_delay_q  <= cfg_data_i[7:0];
        REG_FILTER_ALPHA:        filter_alpha_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register and handshake
  logic            in_vld_q;
  logic [IN_W-1:0] in_data_q;
  logic            out_free;
  logic            advance;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
  end

  // per-motor state and shared brake state
  logic [1:0]           off_q, off_d, stop_q, stop_d;
  logic [7:0]           cnt_q [2];
  logic [7:0]           cnt_d [2];
  logic signed [AW-1:0] acc_q [2];
  logic signed [AW-1:0] acc_d [2];
  logic [15:0]          brake_cd_q, brake_cd_d;
  logic                 brake_on_q, brake_on_d;
  logic [7:0]           rel_cd_q, rel_cd_d;

  // per-motor datapath and shared brake logic
  logic [ThrW-1:0]      thr    [2];
  logic [SB-1:0]        spd    [2];
  logic signed [ThrW:0] thr_x  [2];
  logic [ThrW:0]        mag    [2];
  logic [1:0]           off_pre, stop_pre, restart, slow;
  logic signed [AW-1:0] seed   [2];
  logic signed [AW-1:0] acc0   [2];
  logic signed [DW-1:0] diff   [2];
  logic signed [PW-1:0] prod   [2];
  logic signed [AW-1:0] acc_n  [2];
  logic signed [CW-1:0] acc_c  [2];
  logic signed [CW-1:0] lim_c;
  logic [7:0]           cnt_pre [2];
  logic                 both_off, both_stopped, restart_any;
  flags_t               flags;

  assign thr[0] = in_data_q[ThrW-1:0];
  assign thr[1] = in_data_q[2*ThrW-1:ThrW];
  assign spd[0] = in_data_q[2*ThrW+SB-1:2*ThrW];
  assign spd[1] = in_data_q[2*ThrW+2*SB-1:2*ThrW+SB];
  assign lim_c  = $signed({{(CW-31){1'b0}}, rpm_stop_level_q, {FracW{1'b0}}});

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      thr_x[i]   = $signed({thr[i][ThrW-1], thr[i]});
      mag[i]     = thr_x[i][ThrW] ? (ThrW+1)'(-thr_x[i]) : thr_x[i];
      seed[i]    = $signed({spd[i], {FracW{1'b0}}});
      off_pre[i] = off_q[i] || (mag[i] <= {2'b00, stop_level_q});
      acc0[i]    = (!off_q[i] && off_pre[i]) ? seed[i] : acc_q[i];
      diff[i]    = $signed({seed[i][AW-1], seed[i]}) - $signed({acc0[i][AW-1], acc0[i]});
      prod[i]    = diff[i] * $signed({1'b0, filter_alpha_q});
      acc_n[i]   = acc0[i] + $signed(prod[i][FracW+AW-1:FracW]);
      acc_c[i]   = $signed({{(CW-AW){acc_n[i][AW-1]}}, acc_n[i]});
      slow[i]    = (acc_c[i] < lim_c) && (acc_c[i] > -lim_c);
      cnt_pre[i]  = cnt_q[i];
      stop_pre[i] = stop_q[i];
      if (!stop_q[i] && off_pre[i]) begin
        if (slow[i]) begin
          cnt_pre[i] = (cnt_q[i] != 8'd0) ? cnt_q[i] - 8'd1 : 8'd0;
        end else begin
          cnt_pre[i] = settle_ticks_q;
        end
        stop_pre[i] = (cnt_pre[i] == 8'd0);
      end
      restart[i] = mag[i] > {2'b00, restart_level_q};
      off_d[i]   = off_pre[i] && !restart[i];
      stop_d[i]  = stop_pre[i] && !restart[i];
      cnt_d[i]   = restart[i] ? settle_ticks_q : cnt_pre[i];
      acc_d[i]   = acc_n[i];
    end

    both_off     = &off_pre;
    both_stopped = &stop_pre;
    restart_any  = |restart;

    brake_cd_d = brake_cd_q;
    brake_on_d = brake_on_q;
    rel_cd_d   = rel_cd_q;
    if (both_off) begin
      if (both_stopped) begin
        if (brake_cd_q != 16'd0) begin
          brake_cd_d = brake_cd_q - 16'd1;
        end else begin
          brake_on_d = 1'b1;
        end
      end else begin
        brake_cd_d = brake_delay_q;
      end
    end
    if (restart_any) begin
      brake_cd_d = brake_delay_q;
      if (brake_on_d) begin
        rel_cd_d = release_delay_q;
      end
      brake_on_d = 1'b0;
    end
    if (rel_cd_d != 8'd0) begin
      rel_cd_d = rel_cd_d - 8'd1;
    end

    flags.throttle_released = both_off;
    flags.speed_settled     = both_stopped;
    flags.brake_engage      = brake_on_d;
    flags.release_waiting   = (rel_cd_d != 8'd0);
    flags.clear_integrators = restart_any;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q      <= '0;
      stop_q     <= '0;
      cnt_q[0]   <= SettleTicksRst;
      cnt_q[1]   <= SettleTicksRst;
      acc_q[0]   <= '0;
      acc_q[1]   <= '0;
      brake_cd_q <= '0;
      brake_on_q <= 1'b0;
      rel_cd_q   <= '0;
    end else if (advance) begin
      off_q      <= off_d;
      stop_q     <= stop_d;
      cnt_q[0]   <= cnt_d[0];
      cnt_q[1]   <= cnt_d[1];
      acc_q[0]   <= acc_d[0];
      acc_q[1]   <= acc_d[1];
      brake_cd_q <= brake_cd_d;
      brake_on_q <= brake_on_d;
      rel_cd_q   <= rel_cd_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_axis_tdata <= OUT_W'({acc_n[1][AW-1:FracW], acc_n[0][AW-1:FracW], flags});
    end
  end

endmodule

// File: rtl/dmbs_checker.sv
`include "dual_motor_brake_supervisor_defines.svh"

module dmbs_checker
  import dmbs_pkg::*;
#(
  parameter int unsigned SPEED_BITS = 16
) (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    m_axis_tvalid,
  input logic                                    m_axis_tready,
  input logic [((FlagW+2*SPEED_BITS+7)/8)*8-1:0] m_axis_tdata
);

  flags_t flags;

  assign flags = m_axis_tdata[FlagW-1:0];

  `DMBS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `DMBS_ASSERT_IMP(a_restart_drops_brake, m_axis_tvalid && flags.clear_integrators, !flags.brake_engage, "brake on in a restart transaction")
  `DMBS_ASSERT_IMP(a_brake_needs_stop, m_axis_tvalid && flags.brake_engage, flags.throttle_released && flags.speed_settled, "brake on without both motors off and stopped")
  `DMBS_ASSERT_IMP(a_settled_needs_off, m_axis_tvalid && flags.speed_settled, flags.throttle_released, "motors settled without throttle off")

endmodule

bind dual_motor_brake_supervisor dmbs_checker #(
  .SPEED_BITS(SPEED_BITS)
) u_dmbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: dv/testbench.sv
module testbench
  import dmbs_pkg::*;
();

  localparam int unsigned SpeedW     = 16;
  localparam int unsigned InW        = ((2*ThrW+2*SpeedW+7)/8)*8;
  localparam int unsigned OutW       = ((FlagW+2*SpeedW+7)/8)*8;
  localparam int          QuietLimit = 1000;
  localparam int          PhaseTicks = 270;
  localparam logic [CfgIdxW-1:0] RegUnknown = 3'd7;

  typedef struct packed {
    logic signed [15:0] speed_two;
    logic signed [15:0] speed_one;
    logic signed [15:0] throttle_two;
    logic signed [15:0] throttle_one;
  } tick_t;

  typedef struct packed {
    logic signed [15:0] filt_two;
    logic signed [15:0] filt_one;
    flags_t             flags;
  } status_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InW-1:0]       s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutW-1:0]      m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  // predictor configuration
  logic [14:0] stop_lvl       = StopLevelRst;
  logic [14:0] restart_lvl    = RestartLevelRst;
  logic [14:0] rpm_lvl        = RpmStopLevelRst;
  logic [7:0]  settle_reload  = SettleTicksRst;
  logic [15:0] brake_reload   = BrakeDelayRst;
  logic [7:0]  release_reload = ReleaseDelayRst;
  logic [15:0] alpha          = FilterAlphaRst;

  // predictor state
  logic [1:0]  motor_off     = 2'b00;
  logic [1:0]  motor_stopped = 2'b00;
  logic [7:0]  settle_left [2];
  longint      speed_acc [2];
  logic [15:0] brake_left    = '0;
  logic        brake_set     = 1'b0;
  logic [7:0]  release_left  = '0;

  status_t pending_status [$];
  int      mismatch_count = 0;
  int      ticks_sent     = 0;
  int      quiet          = 0;
  int      hold_req       = 0;
  logic    send_idle      = 1'b0;
  logic    recv_idle      = 1'b0;

  dual_motor_brake_supervisor #(
    .SPEED_BITS(SpeedW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic status_t predict_status(tick_t t);
    int      mag [2];
    longint  spd [2];
    longint  lim;
    longint  diff;
    logic    both_off;
    logic    both_stopped;
    logic    restart_seen;
    status_t r;
    mag[0] = int'(t.throttle_one);
    mag[1] = int'(t.throttle_two);
    spd[0] = longint'(t.speed_one);
    spd[1] = longint'(t.speed_two);
    lim = longint'(rpm_lvl) * 65536;
    restart_seen = 1'b0;
    for (int i = 0; i < 2; i++) begin
      if (mag[i] < 0) mag[i] = -mag[i];
      if (!motor_off[i] && mag[i] <= int'(stop_lvl)) begin
        motor_off[i] = 1'b1;
        speed_acc[i] = spd[i] * 65536;
      end
    end
    for (int i = 0; i < 2; i++) begin
      diff = spd[i] * 65536 - speed_acc[i];
      speed_acc[i] = speed_acc[i] + ((diff * longint'(alpha)) >>> 16);
    end
    for (int i = 0; i < 2; i++) begin
      if (!motor_stopped[i] && motor_off[i]) begin
        if (speed_acc[i] < lim && speed_acc[i] > -lim) begin
          if (settle_left[i] != 8'd0) settle_left[i] = settle_left[i] - 8'd1;
        end else begin
          settle_left[i] = settle_reload;
        end
        if (settle_left[i] == 8'd0) motor_stopped[i] = 1'b1;
      end
    end
    both_off     = &motor_off;
    both_stopped = &motor_stopped;
    if (both_off) begin
      if (both_stopped) begin
        if (brake_left != 16'd0) brake_left = brake_left - 16'd1;
        else brake_set = 1'b1;
      end else begin
        brake_left = brake_reload;
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (mag[i] > int'(restart_lvl)) begin
        motor_off[i]     = 1'b0;
        motor_stopped[i] = 1'b0;
        settle_left[i]   = settle_reload;
        restart_seen     = 1'b1;
      end
    end
    if (restart_seen) begin
      brake_left = brake_reload;
      if (brake_set) release_left = release_reload;
      brake_set = 1'b0;
    end
    if (release_left != 8'd0) release_left = release_left - 8'd1;
    r.flags.throttle_released = both_off;
    r.flags.speed_settled     = both_stopped;
    r.flags.brake_engage      = brake_set;
    r.flags.release_waiting   = (release_left != 8'd0);
    r.flags.clear_integrators = restart_seen;
    r.filt_one = 16'(speed_acc[0] >>> 16);
    r.filt_two = 16'(speed_acc[1] >>> 16);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endfunction

  function automatic tick_t mk(int t1, int t2, int s1, int s2);
    tick_t t;
    t.throttle_one = 16'(t1);
    t.throttle_two = 16'(t2);
    t.speed_one    = 16'(s1);
    t.speed_two    = 16'(s2);
    return t;
  endfunction

  function automatic logic signed [15:0] throttle_in(int lo, int hi);
    int m;
    if (lo > 32768) lo = 32768;
    if (hi > 32768) hi = 32768;
    m = int'($urandom_range(hi, lo));
    if (m == 32768) return 16'sh8000;
    return 16'($urandom_range(0, 1) ? -m : m);
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int speed_pick();
    if ($urandom_range(0, 5) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 8000)) - 4000;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_tick(input tick_t t);
    int gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_status.push_back(predict_status(t));
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    unique case (idx)
      REG_STOP_LEVEL:          stop_lvl       = val[14:0];
      REG_RESTART_LEVEL:       restart_lvl    = val[14:0];
      REG_RPM_STOP_LEVEL:      rpm_lvl        = val[14:0];
      REG_SETTLE_TICKS:        settle_reload  = val[7:0];
      REG_BRAKE_DELAY_TICKS:   brake_reload   = val[15:0];
      REG_RELEASE_DELAY_TICKS: release_reload = val[7:0];
      REG_FILTER_ALPHA:        alpha          = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic configure(int stop, int restart, int rpm, int settle, int brake,
                           int rel_ticks, int a);
    write_reg(REG_STOP_LEVEL, CfgDataW'(stop));
    write_reg(REG_RESTART_LEVEL, CfgDataW'(restart));
    write_reg(REG_RPM_STOP_LEVEL, CfgDataW'(rpm));
    write_reg(REG_SETTLE_TICKS, CfgDataW'(settle));
    write_reg(REG_BRAKE_DELAY_TICKS, CfgDataW'(brake));
    write_reg(REG_RELEASE_DELAY_TICKS, CfgDataW'(rel_ticks));
    write_reg(REG_FILTER_ALPHA, CfgDataW'(a));
  endtask

  // run, then coast down with throttles off; some episodes are noise or keep one motor on
  task automatic run_episode();
    int    n;
    int    s1;
    int    s2;
    int    style;
    tick_t t;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 4)) begin
        t = {$urandom, $urandom};
        send_tick(t);
      end
    end else begin
      s1 = speed_pick();
      s2 = speed_pick();
      repeat ($urandom_range(1, 5)) begin
        t.throttle_one = throttle_in(int'(restart_lvl) + 1, 32768);
        t.throttle_two = (style == 3) ? throttle_in(int'(stop_lvl) + 1, int'(restart_lvl))
                                      : throttle_in(int'(restart_lvl) + 1, 32768);
        t.speed_one = 16'(clamp16(s1 + int'($urandom_range(0, 200)) - 100));
        t.speed_two = 16'(clamp16(s2 + int'($urandom_range(0, 200)) - 100));
        send_tick(t);
      end
      n = int'(settle_reload) + int'(brake_reload) + 12;
      if (n > 80) n = 80;
      repeat ($urandom_range(1, n)) begin
        s1 = clamp16(s1 - s1 / 3 + int'($urandom_range(0, 4)) - 2);
        s2 = clamp16(s2 - s2 / 3 + int'($urandom_range(0, 4)) - 2);
        t.throttle_one = throttle_in(0, int'(stop_lvl));
        if (style == 1)
          t.throttle_two = throttle_in(int'(restart_lvl) + 1, 32768);
        else if (style == 2 && $urandom_range(0, 3) == 0)
          t.throttle_two = throttle_in(int'(stop_lvl) + 1, int'(restart_lvl));
        else
          t.throttle_two = throttle_in(0, int'(stop_lvl));
        t.speed_one = 16'(s1);
        t.speed_two = 16'(s2);
        send_tick(t);
      end
    end
  endtask

  task automatic test_reset_values();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_tick(mk(0, 0, 32767, -32768));
    send_tick(mk(-32768, 32767, -32768, 32767));
    send_tick(mk(1638, -1638, 100, -100));
    send_tick(mk(1639, -1639, 0, 0));
    send_tick(mk(3277, -3277, 0, 0));
    send_tick(mk(3278, -3278, 0, 0));
    wait_idle();
  endtask

  // zero settle and brake delay; rpm level zero keeps the slow test false
  task automatic test_zero_delays();
    configure(1638, 3277, 0, 0, 0, 3, 65535);
    write_reg(RegUnknown, 16'hFFFF);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_tick(mk(32767, 32767, 0, 0));
    send_tick(mk(0, 0, 5, -5));
    send_tick(mk(0, 0, -7, 7));
    send_tick(mk(-32768, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0));
    wait_idle();
  endtask

  // filter frozen at the seed: speed exactly at the level is not slow, one below is
  task automatic test_slow_boundary();
    configure(1638, 3277, 100, 2, 1, 2, 0);
    send_tick(mk(20000, -20000, 100, -100));
    send_tick(mk(0, 0, 100, -100));
    send_tick(mk(0, 0, 100, -100));
    send_tick(mk(-20000, 20000, 99, -99));
    repeat (4) send_tick(mk(0, 0, 99, -99));
    send_tick(mk(20000, 0, 0, 0));
    wait_idle();
  endtask

  task automatic test_register_extremes();
    configure(65535, 65535, 65535, 255, 65535, 255, 65535);
    send_tick(mk(32767, -32767, 32767, -32768));
    send_tick(mk(-32768, 0, -32768, 32767));
    send_tick(mk(0, 0, 1, -1));
    send_tick(mk(-32768, -32768, 0, 0));
    wait_idle();
  endtask

  task automatic test_random_phases();
    int target;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        2: begin
          configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          write_reg(RegUnknown, CfgDataW'($urandom));
        end
        3: configure(0, 0, 0, 0, 0, 0, 0);
        default: begin
          target = $urandom_range(0, 3000);
          configure(target, $urandom_range(target, 6000), $urandom_range(50, 3000),
                    $urandom_range(0, 8), $urandom_range(0, 16), $urandom_range(0, 16),
                    $urandom_range(1000, 65535));
        end
      endcase
      send_idle = (phase != 1);
      recv_idle = (phase != 1);
      target = ticks_sent + PhaseTicks;
      while (ticks_sent < target) run_episode();
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    int target;
    configure(1200, 2500, 800, 2, 4, 5, 30000);
    send_idle = 1'b0;
    recv_idle = 1'b1;
    hold_req  = 300;
    target = ticks_sent + 40;
    while (ticks_sent < target) run_episode();
    wait_idle();
  endtask

  task automatic test_sender_pause();
    int target;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (3) begin
      target = ticks_sent + 20;
      while (ticks_sent < target) run_episode();
      wait_idle();
    end
  endtask

  initial begin : result_sink
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) gap = hold_req;
      else gap = recv_idle ? $urandom_range(0, 7) : 0;
      hold_req = 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    status_t got;
    status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[36:0];
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transaction %h", m_axis_tdata);
      end else begin
        want = pending_status.pop_front();
        check_field("throttle_released", 16'(want.flags.throttle_released),
                    16'(got.flags.throttle_released));
        check_field("speed_settled", 16'(want.flags.speed_settled),
                    16'(got.flags.speed_settled));
        check_field("brake_engage", 16'(want.flags.brake_engage),
                    16'(got.flags.brake_engage));
        check_field("release_waiting", 16'(want.flags.release_waiting),
                    16'(got.flags.release_waiting));
        check_field("clear_integrators", 16'(want.flags.clear_integrators),
                    16'(got.flags.clear_integrators));
        check_field("filtered_speed_one", want.filt_one, got.filt_one);
        check_field("filtered_speed_two", want.filt_two, got.filt_two);
        check_field("pad", '0, 16'(m_axis_tdata[OutW-1:37]));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 2; i++) begin
      settle_left[i] = 8'd10;
      speed_acc[i]   = 0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_zero_delays();
    test_slow_boundary();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    test_sender_pause();
    wait_idle();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: dual_motor_brake_supervisor.f
+incdir+rtl
rtl/dmbs_pkg.sv
rtl/dual_motor_brake_supervisor.sv
rtl/dmbs_checker.sv
dv/testbench.sv
